[sv/mpm_pkg.sv]
`default_nettype none

package mpm_pkg;

  // item kinds carried on in_tuser
  localparam logic [2:0] FUNC_LOAD     = 3'd0;
  localparam logic [2:0] FUNC_PLAY     = 3'd1;
  localparam logic [2:0] FUNC_STOP     = 3'd2;
  localparam logic [2:0] FUNC_STOP_ALL = 3'd3;
  localparam logic [2:0] FUNC_SET_VOL  = 3'd4;
  localparam logic [2:0] FUNC_MIX      = 3'd5;

  // field widths
  localparam int ADDR_FIELD_W  = 12;
  localparam int SAMPLE_W      = 16;
  localparam int COUNT_FIELD_W = 13;
  localparam int GAIN_W        = 8;
  localparam int CHAN_W        = 3;
  localparam int ACTIVE_OUT_W  = 4;
  localparam int IN_DATA_W     = 56;
  localparam int OUT_DATA_W    = 24;

  // base + position before the store wrap
  localparam int SUM_W   = 14;
  localparam int MAX_SUM = (2 ** ADDR_FIELD_W - 1) + (2 ** COUNT_FIELD_W - 1);

  // shared multiplier: 24 x 25 unsigned, registered product
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // ceil(2^32 / 255): exact floor(m / 255) for m < 2^24 via (m * RECIP) >> 32
  localparam logic [MUL_B_W-1:0] RECIP_255 = 25'd16843010;
  localparam int QUOT_LSB = 32;
  localparam int QUOT_W   = 17;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

`default_nettype wire

[sv/multichannel_pcm_mixer_top.sv]
// Multichannel PCM mixer: a store of STORE_WORDS signed 16-bit samples and a table of VOICES
// voices, driven by one transaction per command on the in_ stream (in_tuser selects load,
// play, stop, stop all, set volume or mix tick); every command returns exactly one result
// transaction on the out_ stream. One command is worked at a time and in_tready is low until
// its result has been handed to the output register, which can still hold the previous
// result while the next command is taken. Control commands (play, stop, stop all, set
// volume, unused codes) go from the execute state straight to the result; a load runs R
// compare-subtract steps that wrap its address into the store and then writes the sample
// (R = max(1, ceil(log2(12287 / STORE_WORDS))), so R = 2 at 4096 words). A mix tick visits
// every voice in turn: an idle voice is passed over and a just-finished one is cleared, while
// each playing voice goes through the R wrap steps, one store read and two passes of the
// single shared multiplier (sample times volume, then the exact divide by 255 as a
// reciprocal product) before its share is added to the saturating sum.

`default_nettype none

module multichannel_pcm_mixer_top #(
  parameter int VOICES      = 8,
  parameter int STORE_WORDS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // address[11:0], sample_value[27:12], sample_count[40:28], volume[48:41],
  // looping[49], channel[52:50], zero pad[55:53]
  input  wire logic [55:0] in_tdata,
  // func[2:0]
  input  wire logic [2:0]  in_tuser,
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // mixed_sample[15:0], granted[16], granted_channel[19:17], active_count[23:20]
  output logic [23:0]      out_tdata
);

  // widths that follow from the parameters
  localparam int VIDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W     = $clog2(VOICES + 1);
  localparam int ADDR_W    = $clog2(STORE_WORDS);
  localparam int SW_BITS   = $clog2(STORE_WORDS + 1);
  localparam int RED_W     = (mpm_pkg::SUM_W > SW_BITS) ? mpm_pkg::SUM_W : SW_BITS;
  localparam int MOD_STEPS = $clog2((mpm_pkg::MAX_SUM / STORE_WORDS) + 1);
  localparam int RED_STEPS = (MOD_STEPS > 0) ? MOD_STEPS : 1;
  localparam int STEP_W    = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

  localparam int AW = mpm_pkg::ADDR_FIELD_W;
  localparam int SW = mpm_pkg::SAMPLE_W;
  localparam int CW = mpm_pkg::COUNT_FIELD_W;
  localparam int GW = mpm_pkg::GAIN_W;
  localparam int HW = mpm_pkg::CHAN_W;

  localparam logic signed [SW+1:0] SAT_HI = (SW+2)'(mpm_pkg::SAMPLE_MAX);
  localparam logic signed [SW+1:0] SAT_LO = (SW+2)'(mpm_pkg::SAMPLE_MIN);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_VISIT = 4'd2;
  localparam logic [3:0] S_RED   = 4'd3;
  localparam logic [3:0] S_WR    = 4'd4;
  localparam logic [3:0] S_ADDR  = 4'd5;
  localparam logic [3:0] S_MUL1  = 4'd6;
  localparam logic [3:0] S_MUL2  = 4'd7;
  localparam logic [3:0] S_ACC   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state_r, state_nxt;

  // latched command
  logic [2:0]    func_r, func_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [SW-1:0] sval_r, sval_nxt;
  logic [CW-1:0] scount_r, scount_nxt;
  logic [GW-1:0] vol_r, vol_nxt;
  logic          loop_r, loop_nxt;
  logic [HW-1:0] chan_r, chan_nxt;

  // voice table
  logic [VOICES-1:0] active_r, active_nxt;
  logic [AW-1:0]     base_r [VOICES];
  logic [AW-1:0]     base_nxt [VOICES];
  logic [CW-1:0]     len_r [VOICES];
  logic [CW-1:0]     len_nxt [VOICES];
  logic [CW-1:0]     pos_r [VOICES];
  logic [CW-1:0]     pos_nxt [VOICES];
  logic [GW-1:0]     gain_r [VOICES];
  logic [GW-1:0]     gain_nxt [VOICES];
  logic [VOICES-1:0] rep_r, rep_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // mix walk and address wrap
  logic [VIDX_W-1:0]    vi_r, vi_nxt;
  logic [RED_W-1:0]     red_r, red_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic                 neg_r, neg_nxt;
  logic signed [SW-1:0] acc_r, acc_nxt;
  logic                 granted_r, granted_nxt;
  logic [HW-1:0]        gch_r, gch_nxt;

  // result register
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [23:0] out_tdata_r, out_tdata_nxt;

  // shared units
  mpm_pkg::mul_req_t            mul_req;
  logic [mpm_pkg::PROD_W-1:0]   mul_prod;
  logic                         ram_we;
  logic                         ram_re;
  logic [SW-1:0]                ram_rdata;

  // lowest free voice
  logic              free_found;
  logic [VIDX_W-1:0] free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (!active_r[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = VIDX_W'(i);
      end
    end
  end

  // per-step helpers
  logic                 chan_ok;
  logic [VIDX_W-1:0]    chan_idx;
  logic                 last_voice;
  logic                 at_end;
  logic [CW-1:0]        pos_eff;
  logic [RED_W-1:0]     mod_k;
  logic [SW:0]          samp_mag;
  logic [mpm_pkg::QUOT_W-1:0] quot;
  logic signed [SW+1:0] contrib;
  logic signed [SW+1:0] acc_sum;

  assign chan_ok    = int'(chan_r) < VOICES;
  assign chan_idx   = VIDX_W'(chan_r);
  assign last_voice = (vi_r == VIDX_W'(VOICES - 1));
  assign at_end     = (pos_r[vi_r] >= len_r[vi_r]);
  assign pos_eff    = at_end ? '0 : pos_r[vi_r];
  assign mod_k      = RED_W'(STORE_WORDS) << step_r;
  // magnitude of the stored word, sign-extended before negation
  assign samp_mag   = ram_rdata[SW-1] ? ((SW+1)'(0) - {ram_rdata[SW-1], ram_rdata})
                                      : {1'b0, ram_rdata};
  assign quot       = mul_prod[mpm_pkg::QUOT_LSB +: mpm_pkg::QUOT_W];
  assign contrib    = neg_r ? ((SW+2)'(0) - $signed({1'b0, quot}))
                            : $signed({1'b0, quot});
  assign acc_sum    = $signed({{2{acc_r[SW-1]}}, acc_r}) + contrib;

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    addr_nxt       = addr_r;
    sval_nxt       = sval_r;
    scount_nxt     = scount_r;
    vol_nxt        = vol_r;
    loop_nxt       = loop_r;
    chan_nxt       = chan_r;
    active_nxt     = active_r;
    base_nxt       = base_r;
    len_nxt        = len_r;
    pos_nxt        = pos_r;
    gain_nxt       = gain_r;
    rep_nxt        = rep_r;
    cnt_nxt        = cnt_r;
    vi_nxt         = vi_r;
    red_nxt        = red_r;
    step_nxt       = step_r;
    neg_nxt        = neg_r;
    acc_nxt        = acc_r;
    granted_nxt    = granted_r;
    gch_nxt        = gch_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    mul_req        = '0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt   = in_tuser;
          addr_nxt   = in_tdata[11:0];
          sval_nxt   = in_tdata[27:12];
          scount_nxt = in_tdata[40:28];
          vol_nxt    = in_tdata[48:41];
          loop_nxt   = in_tdata[49];
          chan_nxt   = in_tdata[52:50];
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        acc_nxt     = '0;
        granted_nxt = 1'b0;
        gch_nxt     = '0;
        state_nxt   = S_DONE;
        case (func_r)
          mpm_pkg::FUNC_LOAD: begin
            red_nxt   = RED_W'(addr_r);
            step_nxt  = STEP_W'(RED_STEPS - 1);
            state_nxt = S_RED;
          end
          mpm_pkg::FUNC_PLAY: begin
            if (free_found) begin
              active_nxt[free_idx] = 1'b1;
              base_nxt[free_idx]   = addr_r;
              len_nxt[free_idx]    = scount_r;
              pos_nxt[free_idx]    = '0;
              gain_nxt[free_idx]   = vol_r;
              rep_nxt[free_idx]    = loop_r;
              cnt_nxt              = cnt_r + CNT_W'(1);
              granted_nxt          = 1'b1;
              gch_nxt              = HW'(free_idx);
            end
          end
          mpm_pkg::FUNC_STOP: begin
            if (chan_ok && active_r[chan_idx]) begin
              active_nxt[chan_idx] = 1'b0;
              cnt_nxt              = cnt_r - CNT_W'(1);
            end
          end
          mpm_pkg::FUNC_STOP_ALL: begin
            active_nxt = '0;
            cnt_nxt    = '0;
          end
          mpm_pkg::FUNC_SET_VOL: begin
            if (chan_ok) begin
              gain_nxt[chan_idx] = vol_r;
            end
          end
          mpm_pkg::FUNC_MIX: begin
            vi_nxt    = '0;
            state_nxt = S_VISIT;
          end
          default: begin
          end
        endcase
      end

      S_VISIT: begin
        if (active_r[vi_r] && !(at_end && !rep_r[vi_r])) begin
          // playing voice (a repeating voice at its end restarts here)
          red_nxt          = RED_W'(mpm_pkg::SUM_W'(base_r[vi_r]) + mpm_pkg::SUM_W'(pos_eff));
          pos_nxt[vi_r]    = pos_eff + CW'(1);
          step_nxt         = STEP_W'(RED_STEPS - 1);
          state_nxt        = S_RED;
        end else begin
          if (active_r[vi_r]) begin
            active_nxt[vi_r] = 1'b0;
            cnt_nxt          = cnt_r - CNT_W'(1);
          end
          if (last_voice) begin
            state_nxt = S_DONE;
          end else begin
            vi_nxt = vi_r + VIDX_W'(1);
          end
        end
      end

      S_RED: begin
        // restoring wrap: one shifted compare-subtract per cycle
        if (red_r >= mod_k) begin
          red_nxt = red_r - mod_k;
        end
        if (step_r == '0) begin
          state_nxt = (func_r == mpm_pkg::FUNC_LOAD) ? S_WR : S_ADDR;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end

      S_WR: begin
        ram_we    = 1'b1;
        state_nxt = S_DONE;
      end

      S_ADDR: begin
        ram_re    = 1'b1;
        state_nxt = S_MUL1;
      end

      S_MUL1: begin
        mul_req.en = 1'b1;
        mul_req.a  = mpm_pkg::MUL_A_W'(samp_mag);
        mul_req.b  = mpm_pkg::MUL_B_W'(gain_r[vi_r]);
        neg_nxt    = ram_rdata[SW-1];
        state_nxt  = S_MUL2;
      end

      S_MUL2: begin
        mul_req.en = 1'b1;
        mul_req.a  = mul_prod[mpm_pkg::MUL_A_W-1:0];
        mul_req.b  = mpm_pkg::RECIP_255;
        state_nxt  = S_ACC;
      end

      S_ACC: begin
        if (acc_sum > SAT_HI) begin
          acc_nxt = mpm_pkg::SAMPLE_MAX;
        end else if (acc_sum < SAT_LO) begin
          acc_nxt = mpm_pkg::SAMPLE_MIN;
        end else begin
          acc_nxt = acc_sum[SW-1:0];
        end
        if (last_voice) begin
          state_nxt = S_DONE;
        end else begin
          vi_nxt    = vi_r + VIDX_W'(1);
          state_nxt = S_VISIT;
        end
      end

      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {mpm_pkg::ACTIVE_OUT_W'(cnt_r), gch_r, granted_r, acc_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= '0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload, only read once written by a command
  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    addr_r      <= addr_nxt;
    sval_r      <= sval_nxt;
    scount_r    <= scount_nxt;
    vol_r       <= vol_nxt;
    loop_r      <= loop_nxt;
    chan_r      <= chan_nxt;
    base_r      <= base_nxt;
    len_r       <= len_nxt;
    pos_r       <= pos_nxt;
    gain_r      <= gain_nxt;
    rep_r       <= rep_nxt;
    vi_r        <= vi_nxt;
    red_r       <= red_nxt;
    step_r      <= step_nxt;
    neg_r       <= neg_nxt;
    acc_r       <= acc_nxt;
    granted_r   <= granted_nxt;
    gch_r       <= gch_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // sample store
  mpm_ram #(
    .WIDTH (SW),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (red_r[ADDR_W-1:0]),
    .wdata (sval_r),
    .re    (ram_re),
    .raddr (red_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // shared multiplier: volume scaling, then divide by 255
  mpm_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (mul_prod)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // voice count tracks the active bits
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) == $countones(active_r))
    else $error("active count out of step with active voices");

  // one command at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command accepted while another is in flight");

  // wrapped address lies inside the store when read
  a_addr_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADDR |-> red_r < RED_W'(STORE_WORDS))
    else $error("store address not wrapped");

  // scaled sample never exceeds full scale
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACC |-> quot <= mpm_pkg::QUOT_W'(32768))
    else $error("scaled sample out of range");

endmodule

`default_nettype wire

[sv/mpm_ram.sv]
`default_nettype none

module mpm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[sv/mpm_mul.sv]
`default_nettype none

module mpm_mul (
  input  wire logic                           clk,
  input  wire mpm_pkg::mul_req_t              req,
  output logic      [mpm_pkg::PROD_W-1:0]     prod
);

  logic [mpm_pkg::PROD_W-1:0] prod_r;

  // one unsigned product per cycle, registered
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= mpm_pkg::PROD_W'(req.a) * mpm_pkg::PROD_W'(req.b);
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire
